// ===== rtl/core/gsgc_pkg.sv =====
// Shared widths, codes and types for the gyro swipe gesture classifier.
package gsgc_pkg;

	localparam int unsigned RateW   = 16;
	localparam int unsigned DeltaW  = RateW + 1;
	localparam int unsigned VoteW   = 6;
	localparam int unsigned DirW    = 3;
	localparam int unsigned ApbAddrW = 3;
	localparam int unsigned ApbDataW = 32;

	localparam logic [VoteW-1:0] VoteMax = '1;

	localparam logic [RateW-1:0] ThresholdReset = 16'd2000;
	localparam logic [VoteW-1:0] VoteLimitReset = 6'd6;

	// register indexes, decoded from paddr[2]
	localparam logic RegThreshold = 1'b0;
	localparam logic RegVoteLimit = 1'b1;

	localparam logic [DirW-1:0] DirNone = 3'd0;
	localparam logic [DirW-1:0] DirXPos = 3'd1;
	localparam logic [DirW-1:0] DirXNeg = 3'd2;
	localparam logic [DirW-1:0] DirYPos = 3'd3;
	localparam logic [DirW-1:0] DirYNeg = 3'd4;

	typedef struct packed {
		logic cast;    // a vote is cast this step
		logic axis_y;  // vote goes to Y, else X
		logic neg;     // winning change is negative
	} vote_req_t;

	typedef struct packed {
		logic            emit;
		logic [DirW-1:0] direction;
	} decision_t;

endpackage

// ===== rtl/core/gsgc_if.sv =====
// Valid/ready channel interfaces for samples and direction results.
interface gsgc_sample_if;
	import gsgc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [RateW-1:0] x_rate;
	logic signed [RateW-1:0] y_rate;
	modport source (output valid, output x_rate, output y_rate, input ready);
	modport sink (input valid, input x_rate, input y_rate, output ready);
endinterface

interface gsgc_dir_if;
	import gsgc_pkg::*;
	logic            valid;
	logic            ready;
	logic [DirW-1:0] direction;
	modport source (output valid, output direction, input ready);
	modport sink (input valid, input direction, output ready);
endinterface

// ===== rtl/core/gsgc_vote.sv =====
// Vote counters with saturation and the gesture decision.
module gsgc_vote import gsgc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  vote_req_t        req,
	input  logic [VoteW-1:0] vote_limit,
	output decision_t        dec
);

	logic [VoteW-1:0] x_votes_q, y_votes_q;
	logic [VoteW-1:0] x_pos_q, x_neg_q, y_pos_q, y_neg_q;
	logic [VoteW-1:0] x_votes_n, y_votes_n;
	logic [VoteW-1:0] x_pos_n, x_neg_n, y_pos_n, y_neg_n;

	function automatic logic [VoteW-1:0] bump(input logic [VoteW-1:0] c, input logic en);
		bump = (en && c != VoteMax) ? c + 1'b1 : c;
	endfunction

	always_comb begin
		x_votes_n = bump(x_votes_q, req.cast && !req.axis_y);
		y_votes_n = bump(y_votes_q, req.cast && req.axis_y);
		x_pos_n   = bump(x_pos_q, req.cast && !req.axis_y && !req.neg);
		x_neg_n   = bump(x_neg_q, req.cast && !req.axis_y && req.neg);
		y_pos_n   = bump(y_pos_q, req.cast && req.axis_y && !req.neg);
		y_neg_n   = bump(y_neg_q, req.cast && req.axis_y && req.neg);
	end

	// decision on the counts after this step's vote
	always_comb begin
		dec.emit      = (x_votes_n > vote_limit) || (y_votes_n > vote_limit);
		dec.direction = DirNone;
		if (x_votes_n > y_votes_n) begin
			if (x_pos_n > x_neg_n)
				dec.direction = DirXPos;
			else if (x_neg_n > x_pos_n)
				dec.direction = DirXNeg;
		end else if (y_votes_n > x_votes_n) begin
			if (y_pos_n > y_neg_n)
				dec.direction = DirYPos;
			else if (y_neg_n > y_pos_n)
				dec.direction = DirYNeg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_votes_q <= '0;
			y_votes_q <= '0;
			x_pos_q   <= '0;
			x_neg_q   <= '0;
			y_pos_q   <= '0;
			y_neg_q   <= '0;
		end else if (step) begin
			if (dec.emit) begin
				x_votes_q <= '0;
				y_votes_q <= '0;
				x_pos_q   <= '0;
				x_neg_q   <= '0;
				y_pos_q   <= '0;
				y_neg_q   <= '0;
			end else begin
				x_votes_q <= x_votes_n;
				y_votes_q <= y_votes_n;
				x_pos_q   <= x_pos_n;
				x_neg_q   <= x_neg_n;
				y_pos_q   <= y_pos_n;
				y_neg_q   <= y_neg_n;
			end
		end
	end

endmodule

// ===== rtl/core/gyro_swipe_gesture_classifier_core.sv =====
// Top level of the gyro swipe gesture classifier: sample register, deltas, votes, result.
// A sample is registered on transfer; its direction, if any, is loaded into the result
// register when the sample register advances, which waits while a result is not taken.
// Throughput: one sample per cycle while the result side takes each result.
// Reset (arst_n low, asynchronous): previous samples and vote counts to zero, threshold
// to 2000, vote limit to 6, both channels empty.
module gyro_swipe_gesture_classifier_core import gsgc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	gsgc_sample_if.sink         sample,
	gsgc_dir_if.source          result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	logic [RateW-1:0] threshold_q;
	logic [VoteW-1:0] vote_limit_q;

	logic                    s1_valid;
	logic signed [RateW-1:0] x_s1, y_s1;
	logic signed [RateW-1:0] last_x_q, last_y_q;

	logic            out_valid_q;
	logic [DirW-1:0] direction_q;

	logic                     advance;
	logic signed [DeltaW-1:0] dx, dy;
	logic [DeltaW-1:0]        ax, ay;
	logic                     hit;
	vote_req_t                req;
	decision_t                dec;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegVoteLimit) ?
		{{(ApbDataW-VoteW){1'b0}}, vote_limit_q} :
		{{(ApbDataW-RateW){1'b0}}, threshold_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= ThresholdReset;
			vote_limit_q <= VoteLimitReset;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == RegThreshold)
				threshold_q <= pwdata[RateW-1:0];
			else
				vote_limit_q <= pwdata[VoteW-1:0];
		end
	end

	// sample register
	assign advance      = s1_valid && (!out_valid_q || result.ready);
	assign sample.ready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (sample.ready)
			s1_valid <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			x_s1 <= sample.x_rate;
			y_s1 <= sample.y_rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (advance) begin
			last_x_q <= x_s1;
			last_y_q <= y_s1;
		end
	end

	// deltas and vote request
	always_comb begin
		dx  = DeltaW'(x_s1) - DeltaW'(last_x_q);
		dy  = DeltaW'(y_s1) - DeltaW'(last_y_q);
		ax  = dx[DeltaW-1] ? DeltaW'(-dx) : DeltaW'(dx);
		ay  = dy[DeltaW-1] ? DeltaW'(-dy) : DeltaW'(dy);
		hit = (ax >= DeltaW'(threshold_q)) || (ay >= DeltaW'(threshold_q));
		req.cast   = hit && (ax != ay);
		req.axis_y = ay > ax;
		req.neg    = (ay > ax) ? dy[DeltaW-1] : dx[DeltaW-1];
	end

	gsgc_vote u_vote (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.req        (req),
		.vote_limit (vote_limit_q),
		.dec        (dec)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= dec.emit;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && dec.emit)
			direction_q <= dec.direction;
	end

	assign result.valid     = out_valid_q;
	assign result.direction = direction_q;

	// checks
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (direction_q == DirNone || direction_q == DirXPos ||
			direction_q == DirXNeg || direction_q == DirYPos || direction_q == DirYNeg))
		else $error("direction code out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (s1_valid && out_valid_q && !result.ready))
		else $error("sample side stalled without a blocked result");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && dec.emit) |=> out_valid_q)
		else $error("decision lost on its way to the result register");

	a_no_vote_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !dec.emit) |=> !out_valid_q)
		else $error("result presented with no decision");

endmodule
